[rtl/qsb_pkg.sv]
// ----------------------------------------------------------------------------
// Quad sprite batcher package
// Shared payload types, codes, command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package qsb_pkg;

  localparam int SLOT_W     = 5;
  localparam int SLOT_DEPTH = 32;
  localparam int USED_W     = 6;
  localparam int QUAD_W     = 14;
  localparam int TEX_W      = 16;

  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_BEGIN = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  localparam logic [1:0] KIND_VERT = 2'd0;
  localparam logic [1:0] KIND_BIND = 2'd1;
  localparam logic [1:0] KIND_DRAW = 2'd2;

  // Corner i of the unit square: bit i set in a NEG mask means the coordinate is negative.
  localparam logic [3:0] CORNER_NEG_X = 4'b0011;
  localparam logic [3:0] CORNER_NEG_Y = 4'b0110;
  localparam logic [3:0] CORNER_U     = 4'b1100;
  localparam logic [3:0] CORNER_V     = 4'b1001;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic [15:0]        angle;
    logic [31:0]        color;
    logic               textured;
    logic [15:0]        texture_id;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               tex_u;
    logic               tex_v;
    logic [31:0]        vert_color;
    logic [4:0]         slot;
    logic [15:0]        bound_texture;
    logic [15:0]        index_count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic              load;
    logic              batch_clear;
    logic              quad_inc;
    logic              alloc;
    logic              set_slot;
    logic              clr_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] idx;
    logic              emit_bind;
    logic              emit_draw;
    logic              emit_vert;
    logic              last;
    logic [1:0]        corner;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        func;
    logic              textured;
    logic              full;
    logic              quads_zero;
    logic [USED_W-1:0] slots_used;
    logic              match;
    logic              out_free;
  } status_t;

endpackage

`default_nettype wire

[rtl/qsb_if.sv]
// ----------------------------------------------------------------------------
// Quad sprite batcher channel interfaces
// Valid/ready channels for items, results and the configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsb_item_if;
  logic           valid;
  logic           ready;
  qsb_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qsb_result_if;
  logic             valid;
  logic             ready;
  qsb_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/qsb_datapath.sv]
// ----------------------------------------------------------------------------
// Quad sprite batcher datapath
// Item registers, slot memory, batch counters, sine pipeline, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qsb_datapath #(
  parameter int MAX_QUADS = 8192,
  parameter int TEX_SLOTS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qsb_pkg::item_t    item_i,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire qsb_pkg::cmd_t     cmd_i,
  output qsb_pkg::status_t       status_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output qsb_pkg::result_t       result_o
);

  qsb_pkg::item_t item_q;
  logic [15:0]    white_q;
  logic [qsb_pkg::USED_W-1:0] used_q;
  logic [qsb_pkg::QUAD_W-1:0] quads_q;
  logic [qsb_pkg::SLOT_W-1:0] slot_q;
  logic [15:0]    slot_mem [qsb_pkg::SLOT_DEPTH];
  logic [15:0]    rd_data_q;
  logic           out_valid_q;
  qsb_pkg::result_t result_q, result_d;

  // Sine lane 0, cosine lane 1.
  logic [15:0]        ang   [2];
  logic [14:0]        kq    [2];
  logic [29:0]        ksq   [2];
  logic [14:0]        k1_q  [2], k2_q [2], k3_q [2];
  logic               n1_q  [2], n2_q [2], n3_q [2];
  logic [14:0]        t1_q  [2], t2_q [2];
  logic [11:0]        a2_q  [2];
  logic [14:0]        m3_q  [2];
  logic [25:0]        pa    [2];
  logic [29:0]        pm    [2];
  logic [30:0]        pr    [2];
  logic [16:0]        rr    [2];
  logic [15:0]        mag   [2];
  logic signed [15:0] trig_q [2];
  logic signed [47:0] csx_q, ssx_q, csy_q, ssy_q;

  logic signed [50:0] vx, vy, tx, ty;
  logic               neg_x, neg_y;

  function automatic logic signed [31:0] round_sat(input logic signed [50:0] v);
    logic signed [50:0] r;
    logic signed [35:0] q;
    r = v + 51'sd16384;
    q = 36'(r >>> 15);
    if (q > 36'sh07FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (q < -36'sh080000000) begin
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q <= '0;
      used_q  <= qsb_pkg::USED_W'(1);
      quads_q <= '0;
    end else begin
      if (cfg_we_i) begin
        white_q <= cfg_data_i;
      end
      if (cmd_i.batch_clear) begin
        used_q  <= qsb_pkg::USED_W'(1);
        quads_q <= '0;
      end else begin
        if (cmd_i.alloc) begin
          used_q <= used_q + 1'b1;
        end
        if (cmd_i.quad_inc) begin
          quads_q <= quads_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      slot_mem[used_q[qsb_pkg::SLOT_W-1:0]] <= item_q.texture_id;
      slot_q <= used_q[qsb_pkg::SLOT_W-1:0];
    end else if (cmd_i.set_slot) begin
      slot_q <= cmd_i.idx;
    end else if (cmd_i.clr_slot) begin
      slot_q <= '0;
    end
    rd_data_q <= (cmd_i.rd_addr == '0) ? white_q : slot_mem[cmd_i.rd_addr];
  end

  // Quarter-wave polynomial sine, one multiply per stage.
  always_comb begin
    ang[0] = item_q.angle;
    ang[1] = item_q.angle + 16'd16384;
    for (int l = 0; l < 2; l++) begin
      kq[l]  = ang[l][14] ? 15'(15'd16384 - {1'b0, ang[l][13:0]}) : {1'b0, ang[l][13:0]};
      ksq[l] = 30'(kq[l]) * 30'(kq[l]);
      pa[l]  = 26'(t1_q[l]) * 26'd2320;
      pm[l]  = 30'(t2_q[l]) * 30'(15'd21024 - 15'(a2_q[l]));
      pr[l]  = 31'(k3_q[l]) * 31'(16'd51472 - 16'(m3_q[l]));
      rr[l]  = pr[l][30:14];
      mag[l] = (rr[l] > 17'd32767) ? 16'd32767 : rr[l][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      k1_q[l]   <= kq[l];
      n1_q[l]   <= ang[l][15];
      t1_q[l]   <= ksq[l][28:14];
      k2_q[l]   <= k1_q[l];
      n2_q[l]   <= n1_q[l];
      t2_q[l]   <= t1_q[l];
      a2_q[l]   <= pa[l][25:14];
      k3_q[l]   <= k2_q[l];
      n3_q[l]   <= n2_q[l];
      m3_q[l]   <= pm[l][28:14];
      trig_q[l] <= n3_q[l] ? -$signed(mag[l]) : $signed(mag[l]);
    end
    csx_q <= 48'(trig_q[1]) * 48'(item_q.scale_x);
    ssx_q <= 48'(trig_q[0]) * 48'(item_q.scale_x);
    csy_q <= 48'(trig_q[1]) * 48'(item_q.scale_y);
    ssy_q <= 48'(trig_q[0]) * 48'(item_q.scale_y);
  end

  always_comb begin
    neg_x = qsb_pkg::CORNER_NEG_X[cmd_i.corner];
    neg_y = qsb_pkg::CORNER_NEG_Y[cmd_i.corner];
    tx = neg_x ? -51'(csx_q) : 51'(csx_q);
    ty = neg_x ? -51'(ssx_q) : 51'(ssx_q);
    vx = (51'(item_q.pos_x) <<< 15) + tx + (neg_y ? 51'(ssy_q) : -51'(ssy_q));
    vy = (51'(item_q.pos_y) <<< 15) + ty + (neg_y ? -51'(csy_q) : 51'(csy_q));

    result_d      = '0;
    result_d.last = cmd_i.last;
    if (cmd_i.emit_vert) begin
      result_d.kind       = qsb_pkg::KIND_VERT;
      result_d.vert_x     = round_sat(vx);
      result_d.vert_y     = round_sat(vy);
      result_d.vert_z     = item_q.pos_z;
      result_d.tex_u      = qsb_pkg::CORNER_U[cmd_i.corner];
      result_d.tex_v      = qsb_pkg::CORNER_V[cmd_i.corner];
      result_d.vert_color = item_q.color;
      result_d.slot       = slot_q;
    end else if (cmd_i.emit_bind) begin
      result_d.kind          = qsb_pkg::KIND_BIND;
      result_d.slot          = cmd_i.idx;
      result_d.bound_texture = rd_data_q;
    end else begin
      result_d.kind        = qsb_pkg::KIND_DRAW;
      result_d.index_count = 16'(17'(quads_q) * 17'd6);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_vert || cmd_i.emit_bind || cmd_i.emit_draw) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_vert || cmd_i.emit_bind || cmd_i.emit_draw) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_comb begin
    status_o.func       = item_q.func;
    status_o.textured   = item_q.textured;
    status_o.full       = (quads_q >= qsb_pkg::QUAD_W'(MAX_QUADS))
                       || (used_q >= qsb_pkg::USED_W'(TEX_SLOTS));
    status_o.quads_zero = (quads_q == '0);
    status_o.slots_used = used_q;
    status_o.match      = (rd_data_q == item_q.texture_id);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

[rtl/qsb_ctrl.sv]
// ----------------------------------------------------------------------------
// Quad sprite batcher controller
// Sequences batch clear, flush, slot search, trig wait and vertex emission.
// ----------------------------------------------------------------------------
`default_nettype none

module qsb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire qsb_pkg::status_t status_i,
  output qsb_pkg::cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_FL_RD   = 4'd2;
  localparam logic [3:0] S_FL_OUT  = 4'd3;
  localparam logic [3:0] S_FL_DRAW = 4'd4;
  localparam logic [3:0] S_PREP    = 4'd5;
  localparam logic [3:0] S_SR_RD   = 4'd6;
  localparam logic [3:0] S_SR_CMP  = 4'd7;
  localparam logic [3:0] S_WAIT    = 4'd8;
  localparam logic [3:0] S_VERT    = 4'd9;

  // Last index value in S_WAIT, covering the sine and product pipeline.
  localparam logic [5:0] WAIT_LAST = 6'd3;

  logic [3:0] state_q, state_d;
  logic [5:0] idx_q, idx_d;
  logic [1:0] corner_q, corner_d;
  logic       end_q, end_d;
  logic [5:0] idx_inc;

  assign in_ready_o = (state_q == S_IDLE);
  assign idx_inc    = idx_q + 6'd1;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    corner_d = corner_q;
    end_d    = end_q;
    cmd_o         = '0;
    cmd_o.rd_addr = idx_q[4:0];
    cmd_o.idx     = idx_q[4:0];
    cmd_o.corner  = corner_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        idx_d = '0;
        case (status_i.func)
          qsb_pkg::FUNC_DRAW: begin
            end_d   = 1'b0;
            state_d = status_i.full ? S_FL_RD : S_PREP;
          end
          qsb_pkg::FUNC_BEGIN: begin
            cmd_o.batch_clear = 1'b1;
            state_d           = S_IDLE;
          end
          qsb_pkg::FUNC_END: begin
            end_d   = 1'b1;
            state_d = status_i.quads_zero ? S_IDLE : S_FL_RD;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_FL_RD: begin
        state_d = S_FL_OUT;
      end
      S_FL_OUT: begin
        if (status_i.out_free) begin
          cmd_o.emit_bind = 1'b1;
          idx_d           = idx_inc;
          state_d         = (idx_inc == status_i.slots_used) ? S_FL_DRAW : S_FL_RD;
        end
      end
      S_FL_DRAW: begin
        if (status_i.out_free) begin
          cmd_o.emit_draw = 1'b1;
          cmd_o.last      = end_q;
          if (end_q) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.batch_clear = 1'b1;
            state_d           = S_PREP;
          end
        end
      end
      S_PREP: begin
        idx_d = '0;
        if (status_i.textured) begin
          state_d = S_SR_RD;
        end else begin
          cmd_o.clr_slot = 1'b1;
          state_d        = S_WAIT;
        end
      end
      S_SR_RD: begin
        state_d = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (status_i.match) begin
          cmd_o.set_slot = 1'b1;
          idx_d          = '0;
          state_d        = S_WAIT;
        end else if (idx_inc == status_i.slots_used) begin
          cmd_o.alloc = 1'b1;
          idx_d       = '0;
          state_d     = S_WAIT;
        end else begin
          idx_d   = idx_inc;
          state_d = S_SR_RD;
        end
      end
      S_WAIT: begin
        idx_d = idx_inc;
        if (idx_q == WAIT_LAST) begin
          corner_d = '0;
          state_d  = S_VERT;
        end
      end
      S_VERT: begin
        if (status_i.out_free) begin
          cmd_o.emit_vert = 1'b1;
          cmd_o.last      = (corner_q == 2'd3);
          corner_d        = corner_q + 2'd1;
          if (corner_q == 2'd3) begin
            cmd_o.quad_inc = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      corner_q <= '0;
      end_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      corner_q <= corner_d;
      end_q    <= end_d;
    end
  end

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_vert || cmd_o.emit_bind || cmd_o.emit_draw) |-> status_i.out_free)
    else $error("result loaded into a busy output register");

  // A new slot is only taken while the slot table has room.
  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc |-> (status_i.slots_used < 6'd32))
    else $error("slot allocated beyond the table");

  // The fourth vertex closes the item.
  a_vert_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_vert && corner_q == 2'd3) |=> (state_q == S_IDLE))
    else $error("quad did not finish after its fourth vertex");

  // Only one kind of result is loaded per cycle.
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit_vert, cmd_o.emit_bind, cmd_o.emit_draw}))
    else $error("several results loaded at once");

endmodule

`default_nettype wire

[rtl/quad_sprite_batcher_core.sv]
// ----------------------------------------------------------------------------
// Quad sprite batcher core
// Batches textured and untextured quads into slot bindings, draw commands and vertices.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                 Transfer when
//   item_i    in         qsb_pkg::item_t         item_i.valid && item_i.ready
//   result_o  out        qsb_pkg::result_t       result_o.valid && result_o.ready
//   cfg_i     in         white texture id (16b)  cfg_i.valid && cfg_i.ready
//
// A draw quad waits on the sine and product pipeline and searches the slots one
// at a time; a flush emits one binding per slot in use and then the draw
// command.
// Reset empties the batch, clears the white texture id and leaves one slot in use.
// The block takes one item at a time; a stalled output holds the sequencer, and
// the last result waits in the output register while the next item transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_sprite_batcher_core #(
  parameter int MAX_QUADS = 8192,
  parameter int TEX_SLOTS = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qsb_item_if.sink    item_i,
  qsb_result_if.source result_o,
  qsb_cfg_if.sink     cfg_i
);

  qsb_pkg::cmd_t    cmd;
  qsb_pkg::status_t status;

  // The white texture register is always able to take a write.
  assign cfg_i.ready = 1'b1;

  qsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qsb_datapath #(
    .MAX_QUADS (MAX_QUADS),
    .TEX_SLOTS (TEX_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .result_o    (result_o.data)
  );

endmodule

`default_nettype wire
